// ----- hw/rtl/srec_pkg.sv -----
// ----------------------------------------------------------------------------
// S-record encoder package
// Word types, character constants and lookup functions for the S2 line
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package srec_pkg;

  // Depth of the line buffer and width of its fill counter (holds 0..16).
  localparam int unsigned StoreDepth = 16;
  localparam int unsigned FillW      = 5;
  localparam int unsigned AddrW      = 24;
  localparam int unsigned CharW      = 7;
  localparam int unsigned StopLen    = 13;

  // Bytes the count covers besides the data: three address bytes, checksum.
  localparam logic [FillW-1:0] CountExtra = 5'd4;

  localparam logic [CharW-1:0] CharS  = 7'h53;
  localparam logic [CharW-1:0] Char2  = 7'h32;
  localparam logic [CharW-1:0] CharNl = 7'h0A;

  localparam logic CmdData   = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             last_char;
  } out_word_t;

  // Upper-case ASCII hex digit for one nibble.
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] ch;
    if (nib < 4'd10) begin
      ch = 7'h30 + {3'b000, nib};
    end else begin
      ch = 7'h37 + {3'b000, nib};
    end
    return ch;
  endfunction

  // Fixed S8 terminator text, one character per index.
  function automatic logic [CharW-1:0] stop_char(input logic [3:0] idx);
    logic [CharW-1:0] ch;
    case (idx)
      4'd0:    ch = CharS;
      4'd1:    ch = 7'h38;
      4'd2:    ch = 7'h30;
      4'd3:    ch = 7'h34;
      4'd10:   ch = 7'h46;
      4'd11:   ch = 7'h42;
      4'd12:   ch = CharNl;
      default: ch = 7'h30;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/srecord_s2_line_encoder.sv -----
// ----------------------------------------------------------------------------
// S2 S-record line encoder
// Collects raw bytes into lines and emits each line as upper-case S2 record
// text, one character per output word, followed by the S8 terminator on finish.
// ----------------------------------------------------------------------------
// Output: a word that fills a line or finishes a run starts the sequencer, and
//   its first character comes from the output register; a record of n bytes
//   is 13 + 2n characters. Words are taken only in idle, not while a record or
//   the terminator goes out, at one character a cycle while the sink is ready.
// Reset: asynchronous, active low; clears the sequencer, the fill count, the
//   run flag, the address and the load address register.
`default_nettype none

module srecord_s2_line_encoder #(
  parameter int unsigned LINE_BYTES = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Configuration: load address of the first record in a run.
  input  wire                          cfg_we_i,
  input  wire [srec_pkg::AddrW-1:0]    cfg_wdata_i,
  // Input word channel.
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire srec_pkg::in_word_t      in_data_i,
  // Output character channel.
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output srec_pkg::out_word_t          out_data_o
);

  localparam int unsigned FillW = srec_pkg::FillW;
  localparam int unsigned AddrW = srec_pkg::AddrW;
  localparam logic [FillW-1:0] LineFull = FillW'(LINE_BYTES);
  localparam logic [3:0] StopLast = 4'(srec_pkg::StopLen - 1);

  // The sequencer walks the record: "S2", then every record byte as two hex
  // digits, then a newline, and on finish the fixed terminator.
  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_HDR_S   = 6'b000010,
    ST_HDR_2   = 6'b000100,
    ST_BYTE_HI = 6'b001000,
    ST_BYTE_LO = 6'b010000,
    ST_TERM    = 6'b100000
  } state_e;

  // The newline closes the record; it rides on ST_BYTE_LO of the checksum
  // byte via a separate flag to keep the state count small.
  state_e state_q, state_d;

  logic [AddrW-1:0] load_addr_q;
  logic [AddrW-1:0] next_addr_q, next_addr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             run_open_q, run_open_d;
  logic             finish_q, finish_d;
  logic             newline_q, newline_d;
  logic [FillW-1:0] byte_idx_q, byte_idx_d;
  logic [3:0]       term_idx_q, term_idx_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       line_mem [srec_pkg::StoreDepth];
  logic [7:0]       mem_rd_q;

  logic                 out_valid_q, out_valid_d;
  srec_pkg::out_word_t  out_q, out_d;

  logic             in_acc;
  logic             step;
  logic [FillW-1:0] fill_inc;
  logic [FillW-1:0] last_idx;
  logic [FillW-1:0] rd_idx;
  logic             at_chk;
  logic [7:0]       cur_byte;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  // The output register can take a new character when it is empty or its
  // current character leaves this cycle.
  assign step        = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign fill_inc = fill_q + 5'd1;
  assign last_idx = fill_q + srec_pkg::CountExtra;
  // The line buffer is read through a register at the next byte index, so the
  // stored byte is ready in that register when the walk reaches it.
  assign rd_idx   = byte_idx_d - srec_pkg::CountExtra;
  assign at_chk   = (byte_idx_q == last_idx);

  // Record byte selected by the byte index: count, address high to low,
  // the stored data, and finally the checksum.
  always_comb begin
    case (byte_idx_q)
      5'd0:    cur_byte = 8'(fill_q) + 8'(srec_pkg::CountExtra);
      5'd1:    cur_byte = next_addr_q[23:16];
      5'd2:    cur_byte = next_addr_q[15:8];
      5'd3:    cur_byte = next_addr_q[7:0];
      default: begin
        if (at_chk) begin
          cur_byte = ~sum_q;
        end else begin
          cur_byte = mem_rd_q;
        end
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    next_addr_d = next_addr_q;
    fill_d      = fill_q;
    run_open_d  = run_open_q;
    finish_d    = finish_q;
    newline_d   = newline_q;
    byte_idx_d  = byte_idx_q;
    term_idx_d  = term_idx_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          byte_idx_d = '0;
          term_idx_d = '0;
          sum_d      = '0;
          newline_d  = 1'b0;
          finish_d   = (in_data_i.cmd == srec_pkg::CmdFinish);
          if (in_data_i.cmd == srec_pkg::CmdData) begin
            // The first byte of a run picks up the configured load address.
            if (!run_open_q) begin
              next_addr_d = load_addr_q;
              run_open_d  = 1'b1;
            end
            fill_d = fill_inc;
            if (fill_inc >= LineFull) begin
              state_d = ST_HDR_S;
            end
          end else begin
            if (fill_q != '0) begin
              state_d = ST_HDR_S;
            end else begin
              state_d = ST_TERM;
            end
          end
        end
      end
      ST_HDR_S: begin
        if (step) begin
          out_valid_d        = 1'b1;
          out_d.out_char     = srec_pkg::CharS;
          out_d.last_char    = 1'b0;
          state_d            = ST_HDR_2;
        end
      end
      ST_HDR_2: begin
        if (step) begin
          out_valid_d        = 1'b1;
          out_d.out_char     = srec_pkg::Char2;
          out_d.last_char    = 1'b0;
          state_d            = ST_BYTE_HI;
        end
      end
      ST_BYTE_HI: begin
        if (step) begin
          out_valid_d     = 1'b1;
          out_d.out_char  = srec_pkg::hex_char(cur_byte[7:4]);
          out_d.last_char = 1'b0;
          // Every byte but the checksum itself enters the running sum.
          if (!at_chk) begin
            sum_d = sum_q + cur_byte;
          end
          state_d = ST_BYTE_LO;
        end
      end
      ST_BYTE_LO: begin
        if (step) begin
          out_valid_d = 1'b1;
          if (newline_q) begin
            // Record complete: a data record ends the output here, a finish
            // goes on with the terminator.
            out_d.out_char  = srec_pkg::CharNl;
            out_d.last_char = !finish_q;
            next_addr_d     = next_addr_q + AddrW'(fill_q);
            fill_d          = '0;
            newline_d       = 1'b0;
            state_d         = finish_q ? ST_TERM : ST_IDLE;
          end else begin
            out_d.out_char  = srec_pkg::hex_char(cur_byte[3:0]);
            out_d.last_char = 1'b0;
            if (at_chk) begin
              newline_d = 1'b1;
            end else begin
              byte_idx_d = byte_idx_q + 5'd1;
              state_d    = ST_BYTE_HI;
            end
          end
        end
      end
      ST_TERM: begin
        if (step) begin
          out_valid_d     = 1'b1;
          out_d.out_char  = srec_pkg::stop_char(term_idx_q);
          out_d.last_char = (term_idx_q == StopLast);
          term_idx_d      = term_idx_q + 4'd1;
          if (term_idx_q == StopLast) begin
            run_open_d = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_addr_q <= '0;
      next_addr_q <= '0;
      fill_q      <= '0;
      run_open_q  <= 1'b0;
      finish_q    <= 1'b0;
      newline_q   <= 1'b0;
      byte_idx_q  <= '0;
      term_idx_q  <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_addr_q <= next_addr_d;
      fill_q      <= fill_d;
      run_open_q  <= run_open_d;
      finish_q    <= finish_d;
      newline_q   <= newline_d;
      byte_idx_q  <= byte_idx_d;
      term_idx_q  <= term_idx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        load_addr_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: output character, the line buffer and its read data.
  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    mem_rd_q <= line_mem[rd_idx[3:0]];
    if (in_acc && (in_data_i.cmd == srec_pkg::CmdData) && !fill_q[FillW-1]) begin
      line_mem[fill_q[3:0]] <= in_data_i.data_byte;
    end
  end

  // The line never holds more bytes than a full record.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LineFull)
    else $error("line fill count exceeds line length");

  // A finish on an empty line goes straight to the terminator.
  a_empty_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.cmd == srec_pkg::CmdFinish && fill_q == '0)
      |=> state_q == ST_TERM)
    else $error("empty finish did not start the terminator");

  // The byte walk never runs past the checksum.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BYTE_HI || state_q == ST_BYTE_LO) |-> byte_idx_q <= last_idx)
    else $error("record byte index past checksum");

  // The end of the terminator closes the run.
  a_run_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TERM && step && term_idx_q == StopLast)
      |=> (!run_open_q && fill_q == '0))
    else $error("run not closed after terminator");

endmodule

`default_nettype wire

// ----- tb/sv/srecord_s2_line_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// S2 line encoder testbench
// Feeds raw bytes and finish words through the valid/ready input channel and
// checks every character against a local predictor of the S2 record text.
// Sender bursts, sink stalls and most load address changes are randomized.
// ----------------------------------------------------------------------------

module srecord_s2_line_encoder_tb;

  localparam int LineBytes    = 16;
  localparam int SettleCycles = 40;
  localparam int HoldCycles   = 400;
  localparam int RandomWords  = 350;

  // Fixed terminator appended after every finish word.
  localparam string StopRecord = "S804000000FB\n";

  // Sink behavior modes; each lasts a random number of cycles.
  typedef enum logic [1:0] {
    SinkOpen,
    SinkCoin,
    SinkSlow,
    SinkMostly
  } sink_mode_e;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [srec_pkg::AddrW-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  srec_pkg::in_word_t         in_word     = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  srec_pkg::out_word_t        out_word;

  // Words waiting for the driver, and characters waiting for the DUT.
  srec_pkg::in_word_t  pending_words[$];
  srec_pkg::out_word_t expected_chars[$];

  int error_count = 0;

  // Set once by the stimulus to make the sink go quiet for a long stretch.
  logic hold_req = 1'b0;

  // Shadow state of the encoder.
  logic [7:0]                 line_buf [srec_pkg::StoreDepth];
  logic [srec_pkg::FillW-1:0] line_fill;
  logic [7:0]                 line_sum;
  logic [srec_pkg::AddrW-1:0] line_addr;
  logic [srec_pkg::AddrW-1:0] load_addr;
  logic                       run_loaded;

  srecord_s2_line_encoder #(
    .LINE_BYTES (LineBytes)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor. Each accepted word appends the characters it causes to
  // expected_chars; the final one of them carries the last flag.
  // --------------------------------------------------------------------------

  function automatic logic [srec_pkg::CharW-1:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 7'(8'h30 + nib);
    end
    return 7'(8'h41 + nib - 4'd10);
  endfunction

  function automatic void push_ascii(input logic [srec_pkg::CharW-1:0] ch);
    srec_pkg::out_word_t w;
    w.out_char  = ch;
    w.last_char = 1'b0;
    expected_chars.push_back(w);
  endfunction

  function automatic void push_hex_byte(input logic [7:0] b);
    push_ascii(nibble_ascii(b[7:4]));
    push_ascii(nibble_ascii(b[3:0]));
  endfunction

  // One S2 record from the held bytes, then the address moves on by the
  // number of data bytes, wrapping at the top of the 24-bit space.
  function automatic void emit_line();
    logic [7:0] count;
    logic [7:0] check;
    count = 8'(line_fill) + 8'(srec_pkg::CountExtra);
    check = line_sum + count + line_addr[23:16] + line_addr[15:8] + line_addr[7:0];
    push_ascii(7'h53);
    push_ascii(7'h32);
    push_hex_byte(count);
    push_hex_byte(line_addr[23:16]);
    push_hex_byte(line_addr[15:8]);
    push_hex_byte(line_addr[7:0]);
    for (int i = 0; i < int'(line_fill); i++) begin
      push_hex_byte(line_buf[i]);
    end
    push_hex_byte(8'hFF - check);
    push_ascii(7'h0A);
    line_addr = line_addr + srec_pkg::AddrW'(line_fill);
    line_fill = '0;
    line_sum  = '0;
  endfunction

  function automatic void encode_word(input srec_pkg::in_word_t w);
    int                  start_size;
    srec_pkg::out_word_t tail;
    start_size = expected_chars.size();
    if (w.cmd == srec_pkg::CmdData) begin
      // The load address is sampled only by the first byte of a run, so a
      // register write in the middle of a run waits for the next one.
      if (!run_loaded) begin
        line_addr  = load_addr;
        run_loaded = 1'b1;
      end
      line_buf[line_fill[3:0]] = w.data_byte;
      line_fill                = line_fill + 5'd1;
      line_sum                 = line_sum + w.data_byte;
      if (int'(line_fill) >= LineBytes) begin
        emit_line();
      end
    end else begin
      // A finish flushes a partial line first; an empty one gives only the
      // terminator.
      if (line_fill != '0) begin
        emit_line();
      end
      for (int i = 0; i < StopRecord.len(); i++) begin
        push_ascii(7'(StopRecord[i]));
      end
      run_loaded = 1'b0;
    end
    if (expected_chars.size() > start_size) begin
      tail = expected_chars[expected_chars.size() - 1];
      tail.last_char = 1'b1;
      expected_chars[expected_chars.size() - 1] = tail;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: tracks register writes, checks accepted characters against the
  // oldest expectation and runs the predictor on every accepted word.
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    srec_pkg::out_word_t want;
    if (!rst_ni) begin
      line_fill  = '0;
      line_sum   = '0;
      line_addr  = '0;
      load_addr  = '0;
      run_loaded = 1'b0;
      expected_chars.delete();
    end else begin
      if (cfg_we_i) begin
        load_addr = cfg_wdata_i;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual char %h last %b",
                   $time, out_word.out_char, out_word.last_char);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_word.out_char !== want.out_char) begin
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.out_char, out_word.out_char);
            error_count++;
          end
          if (out_word.last_char !== want.last_char) begin
            $display("%0t: last_char mismatch: expected %b, actual %b",
                     $time, want.last_char, out_word.last_char);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        encode_word(in_word);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offers queued words in bursts of random length separated by
  // random gaps. A burst may run with no gap at all, so some stretches go
  // at full rate. Once valid is up it holds with the same word until taken.
  // --------------------------------------------------------------------------

  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word    <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_word    <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: switches between ready patterns of its own. When asked, it holds
  // ready low for a long count while the driver keeps offering, so the
  // encoder backs up and stalls its input.
  // --------------------------------------------------------------------------

  sink_mode_e sink_mode  = SinkOpen;
  int         mode_left  = 0;
  int         hold_left  = 0;
  logic       hold_taken = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (sink_mode)
        SinkOpen:   out_ready_i <= 1'b1;
        SinkCoin:   out_ready_i <= 1'($urandom_range(0, 1));
        SinkSlow:   out_ready_i <= ($urandom_range(0, 3) == 0);
        default:    out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------

  function automatic void queue_byte(input logic [7:0] b);
    srec_pkg::in_word_t w;
    w.cmd       = srec_pkg::CmdData;
    w.data_byte = b;
    pending_words.push_back(w);
  endfunction

  // The data field of a finish word is don't-care, so it carries noise.
  function automatic void queue_finish();
    srec_pkg::in_word_t w;
    w.cmd       = srec_pkg::CmdFinish;
    w.data_byte = 8'($urandom_range(0, 255));
    pending_words.push_back(w);
  endfunction

  // Waits until every word is taken and every character has come back,
  // then lets the encoder settle before a register write.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid_i || expected_chars.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_load(input logic [srec_pkg::AddrW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] corner_bytes [16];
    int         random_count;
    int         phase;
    int         phase_count;
    int         run_len;
    int         pick;

    corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                     8'h40, 8'h80, 8'h55, 8'hAA, 8'hFE, 8'h7F, 8'h3C, 8'hC3};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Finish before any data: terminator only, with the reset load address.
    queue_finish();
    drain();

    // A full line near the top of the address space; the address wraps
    // past zero after it.
    write_load(24'hFFFFF8);
    foreach (corner_bytes[i]) begin
      queue_byte(corner_bytes[i]);
    end
    drain();

    // Register written while the run is open: the partial line still uses
    // the wrapped address, the next run starts at the very top and wraps.
    write_load(24'hFFFFFF);
    queue_byte(8'h12);
    queue_byte(8'hE7);
    queue_byte(8'h9D);
    queue_finish();
    queue_byte(8'h5A);
    queue_finish();
    drain();

    // Random phases, each under a new load address. Most words form proper
    // runs of bytes closed by a finish; some runs are full lines exactly,
    // some finishes come on an empty line, and a phase may end mid-run.
    random_count = 0;
    phase        = 0;
    while (random_count < RandomWords) begin
      case (phase)
        0:       write_load(24'h000000);
        1:       write_load(24'hFFFFFF);
        3:       write_load(24'hFFFFF0 | srec_pkg::AddrW'($urandom_range(0, 15)));
        default: write_load(srec_pkg::AddrW'($urandom_range(0, 24'hFFFFFF)));
      endcase
      phase_count = 0;
      while (phase_count < 60) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          run_len = $urandom_range(0, 15);
        end else if (pick < 6) begin
          run_len = LineBytes * $urandom_range(1, 2);
        end else if (pick < 9) begin
          run_len = $urandom_range(1, 50);
        end else begin
          run_len = 0;
        end
        repeat (run_len) queue_byte(8'($urandom_range(0, 255)));
        queue_finish();
        phase_count += run_len + 1;
      end
      if ($urandom_range(0, 2) == 0) begin
        run_len = $urandom_range(1, 20);
        repeat (run_len) queue_byte(8'($urandom_range(0, 255)));
        phase_count += run_len;
      end
      // The long sink hold lands while this phase is still being offered.
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      random_count += phase_count;
      phase++;
      drain();
    end

    queue_finish();
    drain();

    if (error_count == 0) begin
      $display("[srecord_s2_line_encoder] OK");
    end else begin
      $display("[srecord_s2_line_encoder] ERROR");
    end
    $finish;
  end

  // Guard against a hang; far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("[srecord_s2_line_encoder] ERROR");
    $finish;
  end

endmodule
